// ===== hw/rtl/rlec_pkg.sv =====
// Shared types, constants and tables for the RGB LED effect controller.
package rlec_pkg;

   // Default color depth of the PWM levels and counter
   localparam int COLOR_BITS_DEFAULT = 8;

   // Configuration register widths and reset values
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;
   localparam logic [7:0] BLINK_PERIOD_RESET   = 8'd20;
   localparam logic [7:0] BLINK_ON_TICKS_RESET = 8'd10;
   localparam logic [7:0] DEBOUNCE_TICKS_RESET = 8'd10;
   localparam logic [7:0] HOLD_TICKS_RESET     = 8'd90;

   // Key hold counter saturation
   localparam logic [7:0] KEY_SAT = 8'd200;

   // Rainbow color sequence bounds
   localparam logic [3:0] STEP_FIRST = 4'd1;
   localparam logic [3:0] STEP_LAST  = 4'd8;
   localparam logic [3:0] STEP_WRAP  = 4'd4;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BLINK_PERIOD   = 4'd0,
      CSR_BLINK_ON_TICKS = 4'd1,
      CSR_DEBOUNCE_TICKS = 4'd2,
      CSR_HOLD_TICKS     = 4'd3
   } csr_index_type;

   // Effect modes
   typedef enum logic [2:0] {
      MODE_OFF         = 3'd0,
      MODE_RAINBOW     = 3'd1,
      MODE_WHITE_BLINK = 3'd2,
      MODE_RED         = 3'd3,
      MODE_GREEN       = 3'd4,
      MODE_BLUE        = 3'd5,
      MODE_RED_BLINK   = 3'd6
   } mode_type;

   // Input transaction payload
   typedef struct packed {
      logic ms_tick;
      logic key_down;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic       red_pin_n;
      logic       green_pin_n;
      logic       blue_pin_n;
      logic [2:0] mode_now;
      logic       sleep_request;
   } rsp_type;

   // Configuration register set handed to the core
   typedef struct packed {
      logic [7:0] blink_period;
      logic [7:0] blink_on_ticks;
      logic [7:0] debounce_ticks;
      logic [7:0] hold_ticks;
   } cfg_type;

   // Rainbow target mask per color step: bit0 red, bit1 green, bit2 blue
   function automatic logic [2:0] rainbow_mask(input logic [3:0] step);
      logic [2:0] m;
      case (step)
         4'd1:    m = 3'b001;
         4'd2:    m = 3'b011;
         4'd3:    m = 3'b010;
         4'd4:    m = 3'b100;
         4'd5:    m = 3'b101;
         4'd6:    m = 3'b001;
         4'd7:    m = 3'b011;
         4'd8:    m = 3'b010;
         default: m = 3'b000;
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/rlec_core.sv =====
// Effect state and single-pass update logic: PWM, blink phase, key debounce, modes.
module rlec_core #(
   parameter int COLOR_BITS = rlec_pkg::COLOR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rlec_pkg::req_type item,
   input  rlec_pkg::cfg_type cfg,
   output rlec_pkg::rsp_type result
);

   localparam logic [COLOR_BITS-1:0] FULL    = '1;
   localparam logic [COLOR_BITS-1:0] FULL_M1 = {{(COLOR_BITS-1){1'b1}}, 1'b0};
   localparam logic [COLOR_BITS-1:0] DARK    = '0;

   // One fade step of a level toward its target
   function automatic logic [COLOR_BITS-1:0] toward(input logic [COLOR_BITS-1:0] lv,
                                                    input logic [COLOR_BITS-1:0] tg);
      logic [COLOR_BITS-1:0] r;
      if (lv > tg) begin
         r = lv - 1'b1;
      end else if (lv < tg) begin
         r = lv + 1'b1;
      end else begin
         r = lv;
      end
      return r;
   endfunction

   logic [COLOR_BITS-1:0] pwm_count_ff, pwm_count_in;
   logic [7:0]            blink_phase_ff, blink_phase_in;
   logic [7:0]            key_hold_ff, key_hold_in;
   rlec_pkg::mode_type    mode_ff, mode_in;
   logic                  led_enable_ff, led_enable_in;
   logic [COLOR_BITS-1:0] level_red_ff, level_red_in;
   logic [COLOR_BITS-1:0] level_green_ff, level_green_in;
   logic [COLOR_BITS-1:0] level_blue_ff, level_blue_in;
   logic [COLOR_BITS-1:0] target_red_ff, target_red_in;
   logic [COLOR_BITS-1:0] target_green_ff, target_green_in;
   logic [COLOR_BITS-1:0] target_blue_ff, target_blue_in;
   logic [3:0]            color_step_ff, color_step_in;
   logic [7:0]            hold_left_ff, hold_left_in;

   logic                  pin_r, pin_g, pin_b, sleep, press;
   logic [8:0]            phase_inc;
   logic [7:0]            hold_inc;
   logic                  blink_on;
   logic [COLOR_BITS-1:0] fade_r, fade_g, fade_b;
   logic [COLOR_BITS-1:0] tgt_r, tgt_g, tgt_b;
   logic [2:0]            mask;

   assign phase_inc = {1'b0, blink_phase_ff} + 9'd1;
   assign hold_inc  = key_hold_ff + 8'd1;
   assign fade_r    = toward(level_red_ff, target_red_ff);
   assign fade_g    = toward(level_green_ff, target_green_ff);
   assign fade_b    = toward(level_blue_ff, target_blue_ff);

   // Next state and result for one pass
   always_comb begin
      pwm_count_in    = pwm_count_ff;
      blink_phase_in  = blink_phase_ff;
      key_hold_in     = key_hold_ff;
      mode_in         = mode_ff;
      led_enable_in   = led_enable_ff;
      level_red_in    = level_red_ff;
      level_green_in  = level_green_ff;
      level_blue_in   = level_blue_ff;
      target_red_in   = target_red_ff;
      target_green_in = target_green_ff;
      target_blue_in  = target_blue_ff;
      color_step_in   = color_step_ff;
      hold_left_in    = hold_left_ff;
      pin_r = 1'b1;
      pin_g = 1'b1;
      pin_b = 1'b1;
      sleep = 1'b0;
      press = 1'b0;
      blink_on = 1'b0;
      tgt_r = target_red_ff;
      tgt_g = target_green_ff;
      tgt_b = target_blue_ff;
      mask  = 3'b000;

      // PWM compare against the levels from before this pass
      if (led_enable_ff) begin
         pin_r = !(level_red_ff > pwm_count_ff);
         pin_g = !(level_green_ff > pwm_count_ff);
         pin_b = !(level_blue_ff > pwm_count_ff);
         pwm_count_in = (pwm_count_ff >= FULL_M1) ? DARK : pwm_count_ff + 1'b1;
      end

      if (item.ms_tick) begin
         // Blink phase
         blink_phase_in = (phase_inc >= {1'b0, cfg.blink_period}) ? 8'd0 : phase_inc[7:0];

         // Sleep check
         if (mode_ff == rlec_pkg::MODE_OFF && key_hold_ff == 8'd0) begin
            sleep = 1'b1;
         end

         // Key debounce, press on release
         if (item.key_down) begin
            key_hold_in = (hold_inc >= rlec_pkg::KEY_SAT) ? rlec_pkg::KEY_SAT : hold_inc;
         end else begin
            press       = key_hold_ff >= cfg.debounce_ticks;
            key_hold_in = 8'd0;
         end

         // Mode advance
         if (press) begin
            case (mode_ff)
               rlec_pkg::MODE_OFF:         mode_in = rlec_pkg::MODE_RAINBOW;
               rlec_pkg::MODE_RAINBOW:     mode_in = rlec_pkg::MODE_WHITE_BLINK;
               rlec_pkg::MODE_WHITE_BLINK: mode_in = rlec_pkg::MODE_RED;
               rlec_pkg::MODE_RED:         mode_in = rlec_pkg::MODE_GREEN;
               rlec_pkg::MODE_GREEN:       mode_in = rlec_pkg::MODE_BLUE;
               rlec_pkg::MODE_BLUE:        mode_in = rlec_pkg::MODE_RED_BLINK;
               default:                    mode_in = rlec_pkg::MODE_OFF;
            endcase
            if (mode_in == rlec_pkg::MODE_RAINBOW) begin
               color_step_in = rlec_pkg::STEP_FIRST;
               led_enable_in = 1'b1;
            end
            blink_phase_in = 8'd0;
         end

         // Blink lamp from the phase after this tick
         blink_on = blink_phase_in < cfg.blink_on_ticks;

         // Mode effect
         case (mode_in)
            rlec_pkg::MODE_OFF: begin
               led_enable_in = 1'b0;
               pin_r = 1'b1;
               pin_g = 1'b1;
               pin_b = 1'b1;
            end
            rlec_pkg::MODE_RAINBOW: begin
               level_red_in   = fade_r;
               level_green_in = fade_g;
               level_blue_in  = fade_b;
               if (hold_left_ff != 8'd0) begin
                  hold_left_in = hold_left_ff - 8'd1;
               end else begin
                  if (color_step_in >= rlec_pkg::STEP_FIRST &&
                      color_step_in <= rlec_pkg::STEP_LAST) begin
                     mask  = rlec_pkg::rainbow_mask(color_step_in);
                     tgt_r = mask[0] ? FULL : DARK;
                     tgt_g = mask[1] ? FULL : DARK;
                     tgt_b = mask[2] ? FULL : DARK;
                  end
                  target_red_in   = tgt_r;
                  target_green_in = tgt_g;
                  target_blue_in  = tgt_b;
                  // Color reached: next step and start the hold
                  if (fade_r == tgt_r && fade_g == tgt_g && fade_b == tgt_b) begin
                     color_step_in = (color_step_in >= rlec_pkg::STEP_LAST) ?
                                     rlec_pkg::STEP_WRAP : color_step_in + 4'd1;
                     hold_left_in  = cfg.hold_ticks;
                  end
               end
            end
            rlec_pkg::MODE_WHITE_BLINK: begin
               level_red_in   = blink_on ? FULL : DARK;
               level_green_in = blink_on ? FULL : DARK;
               level_blue_in  = blink_on ? FULL : DARK;
            end
            rlec_pkg::MODE_RED: begin
               level_red_in   = FULL;
               level_green_in = DARK;
               level_blue_in  = DARK;
            end
            rlec_pkg::MODE_GREEN: begin
               level_red_in   = DARK;
               level_green_in = FULL;
               level_blue_in  = DARK;
            end
            rlec_pkg::MODE_BLUE: begin
               level_red_in   = DARK;
               level_green_in = DARK;
               level_blue_in  = FULL;
            end
            rlec_pkg::MODE_RED_BLINK: begin
               level_red_in   = blink_on ? FULL : DARK;
               level_green_in = DARK;
               level_blue_in  = DARK;
            end
            default: begin
            end
         endcase
      end

      result.red_pin_n     = pin_r;
      result.green_pin_n   = pin_g;
      result.blue_pin_n    = pin_b;
      result.mode_now      = mode_in;
      result.sleep_request = sleep;
   end

   // State registers, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff    <= '0;
         blink_phase_ff  <= 8'd0;
         key_hold_ff     <= 8'd0;
         mode_ff         <= rlec_pkg::MODE_RAINBOW;
         led_enable_ff   <= 1'b1;
         level_red_ff    <= '0;
         level_green_ff  <= '0;
         level_blue_ff   <= '0;
         target_red_ff   <= '0;
         target_green_ff <= '0;
         target_blue_ff  <= '0;
         color_step_ff   <= 4'd0;
         hold_left_ff    <= 8'd0;
      end else if (fire) begin
         pwm_count_ff    <= pwm_count_in;
         blink_phase_ff  <= blink_phase_in;
         key_hold_ff     <= key_hold_in;
         mode_ff         <= mode_in;
         led_enable_ff   <= led_enable_in;
         level_red_ff    <= level_red_in;
         level_green_ff  <= level_green_in;
         level_blue_ff   <= level_blue_in;
         target_red_ff   <= target_red_in;
         target_green_ff <= target_green_in;
         target_blue_ff  <= target_blue_in;
         color_step_ff   <= color_step_in;
         hold_left_ff    <= hold_left_in;
      end
   end

endmodule

// ===== hw/rtl/rgb_led_effect_controller.sv =====
// Top level: input register, configuration registers, effect core and result register.
// Data path: an accepted transaction waits in the input register until the result
//   register is free, then moves into it; the core's state is updated by that move.
// Throughput: one transaction per cycle while rsp_ready holds, set by single-pass update.
// Reset: synchronous, active high; state returns to rainbow mode with dark levels
//   and the configuration registers return to their defaults.
module rgb_led_effect_controller #(
   parameter int COLOR_BITS = rlec_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rlec_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rlec_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rlec_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rlec_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic              in_valid_ff, in_valid_in;
   rlec_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   rlec_pkg::rsp_type out_data_ff;
   rlec_pkg::rsp_type core_result;
   rlec_pkg::cfg_type cfg_ff, cfg_in;
   logic              advance;

   // Handshake: the held item moves to the result register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // Configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rlec_pkg::CSR_BLINK_PERIOD:   cfg_in.blink_period   = csr_data;
            rlec_pkg::CSR_BLINK_ON_TICKS: cfg_in.blink_on_ticks = csr_data;
            rlec_pkg::CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_data;
            rlec_pkg::CSR_HOLD_TICKS:     cfg_in.hold_ticks     = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         cfg_ff.blink_period   <= rlec_pkg::BLINK_PERIOD_RESET;
         cfg_ff.blink_on_ticks <= rlec_pkg::BLINK_ON_TICKS_RESET;
         cfg_ff.debounce_ticks <= rlec_pkg::DEBOUNCE_TICKS_RESET;
         cfg_ff.hold_ticks     <= rlec_pkg::HOLD_TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   rlec_core #(
      .COLOR_BITS(COLOR_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

endmodule

// ===== hw/rtl/rlec_checker.sv =====
// Port-level checker for the RGB LED effect controller, with its bind.
module rlec_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input rlec_pkg::req_type                   req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input rlec_pkg::rsp_type                   rsp_data,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [rlec_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [rlec_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Input side never stalls while no result is pending
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // Off mode keeps all pins dark
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mode_now == rlec_pkg::MODE_OFF |->
      rsp_data.red_pin_n && rsp_data.green_pin_n && rsp_data.blue_pin_n)
      else $error("pin lit in off mode");

   // Only the seven defined modes appear
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.mode_now != 3'd7)
      else $error("undefined mode reported");

endmodule

bind rgb_led_effect_controller rlec_checker u_checker (.*);
